// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk with arst_n as disable
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property that holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/gdse_pkg.sv =====
// ----------------------------------------------------------------------------
// gdse_pkg
// shared types and constants of the grid shortest-path step engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gdse_pkg;

	localparam int GRID_SIDE = 32;
	localparam int COORD_W   = 5;
	localparam int CELLS     = GRID_SIDE * GRID_SIDE;
	localparam int ADDR_W    = $clog2(CELLS);
	localparam int COUNT_W   = $clog2(CELLS + 1);
	localparam int DIST_W    = 18;
	localparam int SUM_W     = 19;
	localparam int COST_W    = 8;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	typedef enum logic [2:0] {
		T_EMPTY = 3'd0,
		T_WALL  = 3'd1,
		T_START = 3'd2,
		T_END   = 3'd3,
		T_FRONT = 3'd4,
		T_VISIT = 3'd5
	} cell_type_t;

	typedef enum logic [1:0] {
		K_WRITE = 2'd0,
		K_STEP  = 2'd1,
		K_READ  = 2'd2,
		K_NONE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		R_DIR8     = 2'd0,
		R_STRAIGHT = 2'd1,
		R_DIAGONAL = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		D_ZERO  = 2'd0,
		D_PLUS  = 2'd1,
		D_MINUS = 2'd2
	} delta_t;

	// one grid cell as kept in the record memory
	typedef struct packed {
		cell_type_t          ctype;
		logic [DIST_W-1:0]   path_dist;
		logic [COORD_W-1:0]  pcol;
		logic [COORD_W-1:0]  prow;
	} cell_rec_t;

	// one frontier entry
	typedef struct packed {
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
	} entry_t;

	// control broadcast to the frontier chain
	typedef struct packed {
		logic              rotate;
		logic              remove;
		logic              append;
		logic [ADDR_W-1:0] pos;
		entry_t            entry;
	} chain_ctrl_t;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] col,
		input logic [COORD_W-1:0] row);
		return ADDR_W'(int'(col) * GRID_SIDE + int'(row));
	endfunction

	function automatic logic in_grid(input logic [COORD_W-1:0] col,
		input logic [COORD_W-1:0] row);
		return ({1'b0, col} < (COORD_W + 1)'(GRID_SIDE)) &&
			({1'b0, row} < (COORD_W + 1)'(GRID_SIDE));
	endfunction

	// neighbor order: left, up, right, down, then the four diagonals
	function automatic delta_t dir_dcol(input logic [2:0] dir);
		delta_t d;
		case (dir)
			3'd0, 3'd4, 3'd6: d = D_MINUS;
			3'd2, 3'd5, 3'd7: d = D_PLUS;
			default:          d = D_ZERO;
		endcase
		return d;
	endfunction

	function automatic delta_t dir_drow(input logic [2:0] dir);
		delta_t d;
		case (dir)
			3'd1, 3'd4, 3'd5: d = D_MINUS;
			3'd3, 3'd6, 3'd7: d = D_PLUS;
			default:          d = D_ZERO;
		endcase
		return d;
	endfunction

endpackage

// ===== hw/rtl/gdse_ram.sv =====
// ----------------------------------------------------------------------------
// gdse_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gdse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ===== hw/rtl/gdse_cell.sv =====
// ----------------------------------------------------------------------------
// gdse_cell
// one link of the frontier chain: rotates, closes a gap or takes an append
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gdse_cell (
	input  logic                         clk,
	input  logic [gdse_pkg::ADDR_W-1:0]  my_pos,
	input  gdse_pkg::chain_ctrl_t        ctrl,
	input  gdse_pkg::entry_t             nxt,
	output gdse_pkg::entry_t             entry_q
);

	always_ff @(posedge clk) begin
		if (ctrl.rotate) begin
			entry_q <= nxt;
		end else if (ctrl.remove && (my_pos >= ctrl.pos)) begin
			entry_q <= nxt;
		end else if (ctrl.append && (my_pos == ctrl.pos)) begin
			entry_q <= ctrl.entry;
		end
	end

endmodule

// ===== hw/rtl/grid_dijkstra_step_engine.sv =====
// a step visits four neighbors, or eight in eight-direction mode, scans the whole chain for each
// end neighbor and once more to select the next cell; a write or a read needs no scan
// throughput: one item at a time, the next one taken the cycle after the result register loads;
// the frontier scan rotates the whole chain, one entry per cycle past a single compare at its head
// reset: asynchronous, active low; then the record memory is cleared cell by cell
// while the input is stalled (configuration writes still taken)
// ----------------------------------------------------------------------------
// grid_dijkstra_step_engine
// grid shortest-path search, one relax-and-select step per item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module grid_dijkstra_step_engine (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [gdse_pkg::COST_W-1:0]     cfg_data,
	// input items
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      kind,
	input  logic [gdse_pkg::COORD_W-1:0]    cell_col,
	input  logic [gdse_pkg::COORD_W-1:0]    cell_row,
	input  logic [1:0]                      cell_kind,
	// result items
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [gdse_pkg::COORD_W-1:0]    out_col,
	output logic [gdse_pkg::COORD_W-1:0]    out_row,
	output logic [gdse_pkg::DIST_W-1:0]     distance,
	output logic [gdse_pkg::COORD_W-1:0]    parent_col,
	output logic [gdse_pkg::COORD_W-1:0]    parent_row,
	output logic [2:0]                      cell_status,
	output logic                            reached_end,
	output logic                            frontier_empty
);

	localparam int AW = gdse_pkg::ADDR_W;
	localparam int CW = gdse_pkg::COUNT_W;
	localparam int N  = gdse_pkg::CELLS;

	typedef enum logic [10:0] {
		S_CLEAR     = 11'b000_0000_0001,
		S_IDLE      = 11'b000_0000_0010,
		S_CUR_WAIT  = 11'b000_0000_0100,
		S_NB        = 11'b000_0000_1000,
		S_NB_EVAL   = 11'b000_0001_0000,
		S_SCAN      = 11'b000_0010_0000,
		S_SCAN_END  = 11'b000_0100_0000,
		S_SEL_START = 11'b000_1000_0000,
		S_SEL_WAIT  = 11'b001_0000_0000,
		S_REC_WAIT  = 11'b010_0000_0000,
		S_EMIT      = 11'b100_0000_0000
	} state_t;

	// one result record
	typedef struct packed {
		logic [gdse_pkg::COORD_W-1:0] col;
		logic [gdse_pkg::COORD_W-1:0] row;
		gdse_pkg::cell_rec_t          rec;
		logic                         reached;
		logic                         fempty;
	} res_t;

	localparam gdse_pkg::cell_rec_t CLEAR_REC = '{
		ctype: gdse_pkg::T_EMPTY, path_dist: gdse_pkg::DIST_MAX, pcol: '0, prow: '0};
	localparam gdse_pkg::cell_rec_t OOB_REC = '{
		ctype: gdse_pkg::T_WALL, path_dist: gdse_pkg::DIST_MAX, pcol: '0, prow: '0};

	state_t state_q;

	// configuration registers
	logic                        dir8_q;
	logic [gdse_pkg::COST_W-1:0] straight_q;
	logic [gdse_pkg::COST_W-1:0] diagonal_q;

	// search state
	logic [CW-1:0]                count_q;
	logic [gdse_pkg::COORD_W-1:0] cur_col_q;
	logic [gdse_pkg::COORD_W-1:0] cur_row_q;
	logic                         done_q;
	logic [AW-1:0]                clr_cnt_q;

	// step sequencing
	logic [2:0]                   dir_q;
	logic [gdse_pkg::DIST_W-1:0]  cur_dist_q;
	gdse_pkg::entry_t             nb_q;
	logic [AW-1:0]                nb_addr_q;
	gdse_pkg::cell_rec_t          nb_word_q;
	logic                         scan_sel_q;
	logic [CW-1:0]                scan_cnt_q;
	logic                         found_q;

	// scan head pipeline
	logic                         vld_s1;
	gdse_pkg::entry_t             head_s1;
	logic [AW-1:0]                pos_s1;

	// running minimum
	logic                         best_vld_q;
	gdse_pkg::entry_t             best_q;
	logic [AW-1:0]                best_pos_q;
	logic [gdse_pkg::DIST_W-1:0]  best_dist_q;

	// record to report
	gdse_pkg::entry_t             rec_q;
	logic                         rec_oob_q;
	res_t                         res_q;
	res_t                         out_q;
	logic                         out_valid_q;

	// record memory
	logic                         ram_we;
	logic [AW-1:0]                ram_addr;
	gdse_pkg::cell_rec_t          ram_wdata;
	gdse_pkg::cell_rec_t          ram_rdata;

	// frontier chain
	gdse_pkg::entry_t             chain [N];
	gdse_pkg::chain_ctrl_t        chain_ctrl;

	logic in_fire;
	logic emit_go;

	assign in_stall = (state_q != S_IDLE);
	assign in_fire  = in_valid && !in_stall;
	assign emit_go  = (state_q == S_EMIT) && (!out_valid_q || !out_stall);

	// ---------------------------------------------------------------- input decode
	logic                 in_ok;
	logic [AW-1:0]        in_addr;
	gdse_pkg::cell_rec_t  wr_rec;

	always_comb begin
		in_ok   = gdse_pkg::in_grid(cell_col, cell_row);
		in_addr = gdse_pkg::cell_addr(cell_col, cell_row);
		wr_rec.ctype     = gdse_pkg::cell_type_t'({1'b0, cell_kind});
		wr_rec.path_dist = (wr_rec.ctype == gdse_pkg::T_START) ? '0 : gdse_pkg::DIST_MAX;
		wr_rec.pcol      = '0;
		wr_rec.prow      = '0;
	end

	// ---------------------------------------------------------------- neighbor
	logic                         nb_ok;
	gdse_pkg::entry_t             nb;
	logic                         last_dir;

	always_comb begin
		nb_ok  = 1'b1;
		nb.col = cur_col_q;
		nb.row = cur_row_q;
		case (gdse_pkg::dir_dcol(dir_q))
			gdse_pkg::D_MINUS: begin
				nb_ok  = (cur_col_q != '0);
				nb.col = cur_col_q - 1'b1;
			end
			gdse_pkg::D_PLUS: begin
				nb_ok  = (cur_col_q != gdse_pkg::COORD_W'(gdse_pkg::GRID_SIDE - 1));
				nb.col = cur_col_q + 1'b1;
			end
			default: ;
		endcase
		case (gdse_pkg::dir_drow(dir_q))
			gdse_pkg::D_MINUS: begin
				nb_ok  = nb_ok && (cur_row_q != '0);
				nb.row = cur_row_q - 1'b1;
			end
			gdse_pkg::D_PLUS: begin
				nb_ok  = nb_ok && (cur_row_q != gdse_pkg::COORD_W'(gdse_pkg::GRID_SIDE - 1));
				nb.row = cur_row_q + 1'b1;
			end
			default: ;
		endcase
		// diagonals only run in eight-direction mode
		last_dir = (dir_q == 3'd7) || ((dir_q == 3'd3) && !dir8_q);
	end

	// ---------------------------------------------------------------- relaxation
	logic                         relax_ok;
	logic                         nb_is_end;
	logic [gdse_pkg::SUM_W-1:0]   sum;
	logic [gdse_pkg::DIST_W-1:0]  nd;
	gdse_pkg::cell_rec_t          relax_word;

	always_comb begin
		relax_ok  = (ram_rdata.ctype == gdse_pkg::T_EMPTY) ||
			(ram_rdata.ctype == gdse_pkg::T_END) || (ram_rdata.ctype == gdse_pkg::T_FRONT);
		nb_is_end = (ram_rdata.ctype == gdse_pkg::T_END);
		sum = {1'b0, cur_dist_q} +
			gdse_pkg::SUM_W'(dir_q[2] ? diagonal_q : straight_q);
		// saturate at the top of the distance range
		nd = sum[gdse_pkg::DIST_W] ? gdse_pkg::DIST_MAX : sum[gdse_pkg::DIST_W-1:0];
		relax_word = ram_rdata;
		if (ram_rdata.ctype == gdse_pkg::T_EMPTY) begin
			relax_word.ctype = gdse_pkg::T_FRONT;
		end
		if (nd < ram_rdata.path_dist) begin
			relax_word.path_dist = nd;
			relax_word.pcol      = cur_col_q;
			relax_word.prow      = cur_row_q;
		end
	end

	logic sel_is_end;
	assign sel_is_end = (ram_rdata.ctype == gdse_pkg::T_END);

	logic room;
	assign room = (count_q != CW'(N));

	// ---------------------------------------------------------------- memory port
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = gdse_pkg::cell_addr(cur_col_q, cur_row_q);
		ram_wdata = ram_rdata;
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_cnt_q;
				ram_wdata = CLEAR_REC;
			end
			S_IDLE: begin
				if (kind != gdse_pkg::K_STEP) begin
					ram_addr = in_addr;
				end
				ram_we    = in_fire && (kind == gdse_pkg::K_WRITE) && in_ok;
				ram_wdata = wr_rec;
			end
			S_NB: begin
				ram_addr = gdse_pkg::cell_addr(nb.col, nb.row);
			end
			S_NB_EVAL: begin
				ram_addr  = nb_addr_q;
				ram_we    = relax_ok && !nb_is_end;
				ram_wdata = relax_word;
			end
			S_SCAN: begin
				ram_addr = gdse_pkg::cell_addr(chain[0].col, chain[0].row);
			end
			S_SCAN_END: begin
				if (scan_sel_q) begin
					ram_addr = gdse_pkg::cell_addr(best_q.col, best_q.row);
				end else begin
					ram_addr  = nb_addr_q;
					ram_we    = 1'b1;
					ram_wdata = nb_word_q;
				end
			end
			S_SEL_WAIT: begin
				ram_addr        = gdse_pkg::cell_addr(best_q.col, best_q.row);
				ram_we          = !sel_is_end;
				ram_wdata.ctype = gdse_pkg::T_VISIT;
			end
			default: ;
		endcase
	end

	gdse_ram #(
		.WIDTH ($bits(gdse_pkg::cell_rec_t)),
		.DEPTH (N)
	) u_rec_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// ---------------------------------------------------------------- frontier chain
	always_comb begin
		chain_ctrl        = '0;
		chain_ctrl.pos    = count_q[AW-1:0];
		chain_ctrl.entry  = nb_q;
		case (state_q)
			S_SCAN: begin
				chain_ctrl.rotate = (scan_cnt_q != CW'(N));
			end
			S_NB_EVAL: begin
				chain_ctrl.append = relax_ok && (ram_rdata.ctype == gdse_pkg::T_EMPTY) && room;
			end
			S_SCAN_END: begin
				// end cell goes in only if the scan did not see it
				chain_ctrl.append = !scan_sel_q && !found_q && room;
			end
			S_SEL_WAIT: begin
				chain_ctrl.remove = !sel_is_end;
				chain_ctrl.pos    = best_pos_q;
			end
			default: ;
		endcase
	end

	// a full rotation over every link brings the list back to its order
	for (genvar k = 0; k < N; k++) begin : g_cell
		gdse_cell u_cell (
			.clk     (clk),
			.my_pos  (AW'(k)),
			.ctrl    (chain_ctrl),
			.nxt     (chain[(k + 1) % N]),
			.entry_q (chain[k])
		);
	end

	// ---------------------------------------------------------------- control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			dir8_q      <= 1'b0;
			straight_q  <= gdse_pkg::COST_W'(10);
			diagonal_q  <= gdse_pkg::COST_W'(14);
			count_q     <= '0;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			done_q      <= 1'b0;
			clr_cnt_q   <= '0;
			dir_q       <= '0;
			scan_sel_q  <= 1'b0;
			scan_cnt_q  <= '0;
			found_q     <= 1'b0;
			vld_s1      <= 1'b0;
			best_vld_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					gdse_pkg::R_DIR8:     dir8_q     <= cfg_data[0];
					gdse_pkg::R_STRAIGHT: straight_q <= cfg_data;
					gdse_pkg::R_DIAGONAL: diagonal_q <= cfg_data;
					default: ;
				endcase
			end

			// scan head: first strict minimum or a match on the end cell
			if (vld_s1) begin
				if (scan_sel_q) begin
					if (!best_vld_q || (ram_rdata.path_dist < best_dist_q)) begin
						best_vld_q <= 1'b1;
					end
				end else if (head_s1 == nb_q) begin
					found_q <= 1'b1;
				end
			end

			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == AW'(N - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_fire) begin
						case (kind)
							gdse_pkg::K_WRITE: begin
								if (in_ok && (wr_rec.ctype == gdse_pkg::T_START)) begin
									cur_col_q <= cell_col;
									cur_row_q <= cell_row;
								end
								state_q <= S_EMIT;
							end
							gdse_pkg::K_READ: begin
								state_q <= S_REC_WAIT;
							end
							gdse_pkg::K_STEP: begin
								// a finished search only reports the end cell again
								state_q <= done_q ? S_REC_WAIT : S_CUR_WAIT;
							end
							default: ;
						endcase
					end
				end
				S_CUR_WAIT: begin
					dir_q   <= '0;
					state_q <= S_NB;
				end
				S_NB: begin
					if (nb_ok) begin
						state_q <= S_NB_EVAL;
					end else begin
						dir_q   <= dir_q + 1'b1;
						state_q <= last_dir ? S_SEL_START : S_NB;
					end
				end
				S_NB_EVAL: begin
					if (relax_ok && nb_is_end) begin
						scan_sel_q <= 1'b0;
						scan_cnt_q <= '0;
						found_q    <= 1'b0;
						state_q    <= S_SCAN;
					end else begin
						if (chain_ctrl.append) begin
							count_q <= count_q + 1'b1;
						end
						dir_q   <= dir_q + 1'b1;
						state_q <= last_dir ? S_SEL_START : S_NB;
					end
				end
				S_SCAN: begin
					if (scan_cnt_q != CW'(N)) begin
						vld_s1     <= (scan_cnt_q < count_q);
						scan_cnt_q <= scan_cnt_q + 1'b1;
					end else begin
						vld_s1  <= 1'b0;
						state_q <= S_SCAN_END;
					end
				end
				S_SCAN_END: begin
					if (scan_sel_q) begin
						state_q <= S_SEL_WAIT;
					end else begin
						if (chain_ctrl.append) begin
							count_q <= count_q + 1'b1;
						end
						dir_q   <= dir_q + 1'b1;
						state_q <= last_dir ? S_SEL_START : S_NB;
					end
				end
				S_SEL_START: begin
					if (count_q == '0) begin
						state_q <= S_REC_WAIT;
					end else begin
						scan_sel_q <= 1'b1;
						scan_cnt_q <= '0;
						best_vld_q <= 1'b0;
						state_q    <= S_SCAN;
					end
				end
				S_SEL_WAIT: begin
					cur_col_q <= best_q.col;
					cur_row_q <= best_q.row;
					if (sel_is_end) begin
						done_q <= 1'b1;
					end else begin
						count_q <= count_q - 1'b1;
					end
					state_q <= S_EMIT;
				end
				S_REC_WAIT: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------------- datapath
	always_ff @(posedge clk) begin
		if (state_q == S_CUR_WAIT) begin
			cur_dist_q <= ram_rdata.path_dist;
		end
		if ((state_q == S_NB) && nb_ok) begin
			nb_q      <= nb;
			nb_addr_q <= gdse_pkg::cell_addr(nb.col, nb.row);
		end
		if (state_q == S_NB_EVAL) begin
			nb_word_q <= relax_word;
		end

		head_s1 <= chain[0];
		pos_s1  <= scan_cnt_q[AW-1:0];
		if (vld_s1 && scan_sel_q && (!best_vld_q || (ram_rdata.path_dist < best_dist_q))) begin
			best_q      <= head_s1;
			best_pos_q  <= pos_s1;
			best_dist_q <= ram_rdata.path_dist;
		end

		// record to report after a memory read
		if (in_fire) begin
			if (kind == gdse_pkg::K_STEP) begin
				rec_q.col <= cur_col_q;
				rec_q.row <= cur_row_q;
				rec_oob_q <= 1'b0;
			end else begin
				rec_q.col <= cell_col;
				rec_q.row <= cell_row;
				rec_oob_q <= !in_ok;
			end
		end
		if (state_q == S_SEL_START) begin
			rec_q.col <= cur_col_q;
			rec_q.row <= cur_row_q;
			rec_oob_q <= 1'b0;
		end

		case (state_q)
			S_IDLE: begin
				res_q.col     <= cell_col;
				res_q.row     <= cell_row;
				res_q.rec     <= in_ok ? wr_rec : OOB_REC;
				res_q.reached <= done_q;
				res_q.fempty  <= (count_q == '0);
			end
			S_REC_WAIT: begin
				res_q.col     <= rec_q.col;
				res_q.row     <= rec_q.row;
				res_q.rec     <= rec_oob_q ? OOB_REC : ram_rdata;
				res_q.reached <= done_q;
				res_q.fempty  <= (count_q == '0);
			end
			S_SEL_WAIT: begin
				res_q.col     <= best_q.col;
				res_q.row     <= best_q.row;
				res_q.rec     <= ram_rdata;
				if (!sel_is_end) begin
					res_q.rec.ctype <= gdse_pkg::T_VISIT;
				end
				res_q.reached <= done_q || sel_is_end;
				res_q.fempty  <= 1'b0;
			end
			default: ;
		endcase

		if (emit_go) begin
			out_q <= res_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_col        = out_q.col;
	assign out_row        = out_q.row;
	assign distance       = out_q.rec.path_dist;
	assign parent_col     = out_q.rec.pcol;
	assign parent_row     = out_q.rec.prow;
	assign cell_status    = out_q.rec.ctype;
	assign reached_end    = out_q.reached;
	assign frontier_empty = out_q.fempty;

	// ---------------------------------------------------------------- assertions
	`ASSERT_ALWAYS(a_count_bound, count_q <= CW'(N), "frontier count beyond capacity")
	`ASSERT_IMPLIES(a_scan_no_write, state_q == S_SCAN, !ram_we, "memory write during scan")
	`ASSERT_NEXT(a_done_frozen, done_q, $stable(count_q), "frontier changed after finish")
	`ASSERT_IMPLIES(a_clear_quiet, state_q == S_CLEAR, !out_valid_q, "result during clear")

endmodule
